// ----- rtl/isi_pkg.sv -----
// Shared types, constants and helper functions for the strapdown integrator.
package isi_pkg;

   localparam int unsigned SER_TERMS = 14;

   localparam logic [31:0] TICK_PERIOD_RESET = 32'd4295;
   localparam logic [31:0] ONE30_Q = 32'h4000_0000;
   localparam logic signed [63:0] ONE30 = 64'sd1073741824;
   localparam logic signed [63:0] LIM_Q30_VAL = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] LIM_Q47_VAL = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] LIM_DT_VAL = 64'sh0000_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] LIM_FULL_VAL = 64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic [67:0] MA0 = 68'h1000_0000_0000_0000;
   localparam logic [67:0] MA1 = (MA0 * 68'd16) / 68'd6;
   localparam logic [67:0] MA2 = (MA1 * 68'd16) / 68'd20;
   localparam logic [67:0] MA3 = (MA2 * 68'd16) / 68'd42;
   localparam logic [67:0] MA4 = (MA3 * 68'd16) / 68'd72;
   localparam logic [67:0] MA5 = (MA4 * 68'd16) / 68'd110;
   localparam logic [67:0] MA6 = (MA5 * 68'd16) / 68'd156;
   localparam logic [67:0] MA7 = (MA6 * 68'd16) / 68'd210;
   localparam logic [67:0] MA8 = (MA7 * 68'd16) / 68'd272;
   localparam logic [67:0] MA9 = (MA8 * 68'd16) / 68'd342;
   localparam logic [67:0] MA10 = (MA9 * 68'd16) / 68'd420;
   localparam logic [67:0] MA11 = (MA10 * 68'd16) / 68'd506;
   localparam logic [67:0] MA12 = (MA11 * 68'd16) / 68'd600;
   localparam logic [67:0] MA13 = (MA12 * 68'd16) / 68'd702;

   localparam logic [67:0] MB0 = 68'h0800_0000_0000_0000;
   localparam logic [67:0] MB1 = (MB0 * 68'd16) / 68'd12;
   localparam logic [67:0] MB2 = (MB1 * 68'd16) / 68'd30;
   localparam logic [67:0] MB3 = (MB2 * 68'd16) / 68'd56;
   localparam logic [67:0] MB4 = (MB3 * 68'd16) / 68'd90;
   localparam logic [67:0] MB5 = (MB4 * 68'd16) / 68'd132;
   localparam logic [67:0] MB6 = (MB5 * 68'd16) / 68'd182;
   localparam logic [67:0] MB7 = (MB6 * 68'd16) / 68'd240;
   localparam logic [67:0] MB8 = (MB7 * 68'd16) / 68'd306;
   localparam logic [67:0] MB9 = (MB8 * 68'd16) / 68'd380;
   localparam logic [67:0] MB10 = (MB9 * 68'd16) / 68'd462;
   localparam logic [67:0] MB11 = (MB10 * 68'd16) / 68'd552;
   localparam logic [67:0] MB12 = (MB11 * 68'd16) / 68'd650;
   localparam logic [67:0] MB13 = (MB12 * 68'd16) / 68'd756;

   localparam logic signed [63:0] SER_A [SER_TERMS] = '{
      MA0[63:0], -MA1[63:0], MA2[63:0], -MA3[63:0], MA4[63:0], -MA5[63:0],
      MA6[63:0], -MA7[63:0], MA8[63:0], -MA9[63:0], MA10[63:0], -MA11[63:0],
      MA12[63:0], -MA13[63:0]};

   localparam logic signed [63:0] SER_B [SER_TERMS] = '{
      MB0[63:0], -MB1[63:0], MB2[63:0], -MB3[63:0], MB4[63:0], -MB5[63:0],
      MB6[63:0], -MB7[63:0], MB8[63:0], -MB9[63:0], MB10[63:0], -MB11[63:0],
      MB12[63:0], -MB13[63:0]};

   localparam logic [8:0][31:0] ATT_IDENTITY = {
      ONE30_Q, 32'd0, 32'd0, 32'd0, ONE30_Q, 32'd0, 32'd0, 32'd0, ONE30_Q};

   typedef enum logic [1:0] {
      CSR_GRAVITY_X,
      CSR_GRAVITY_Y,
      CSR_GRAVITY_Z,
      CSR_TICK_PERIOD
   } isi_csr_index_type;

   typedef enum logic [2:0] {
      KIND_ROW0,
      KIND_ROW1,
      KIND_ROW2,
      KIND_VEL,
      KIND_POS
   } isi_kind_type;

   typedef enum logic [1:0] {
      LIM_Q30,
      LIM_Q47,
      LIM_DT,
      LIM_FULL
   } isi_lim_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_PROD,
      MUL_SHIFT,
      MUL_CLAMP
   } isi_mul_state_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_DT,
      ENG_TH,
      ENG_SQ,
      ENG_SER,
      ENG_DT2,
      ENG_EMM,
      ENG_EK,
      ENG_EB,
      ENG_NX,
      ENG_U0,
      ENG_U1,
      ENG_T1,
      ENG_T2,
      ENG_DV,
      ENG_DONE
   } isi_eng_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_EMIT
   } isi_top_state_type;

   typedef struct packed {
      logic               restart;
      logic        [31:0] timestamp;
      logic signed [31:0] gyro_x;
      logic signed [31:0] gyro_y;
      logic signed [31:0] gyro_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
   } isi_req_type;

   typedef struct packed {
      logic        [2:0]  kind;
      logic signed [47:0] value_x;
      logic signed [47:0] value_y;
      logic signed [47:0] value_z;
      logic               saturated;
      logic               last;
   } isi_rsp_type;

   typedef struct packed {
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
      logic signed [31:0] gravity_z;
      logic        [31:0] tick_period;
   } isi_cfg_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic        [6:0]  shift;
      isi_lim_type        lim;
   } isi_mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
      logic               ovf;
   } isi_mul_rsp_type;

   typedef struct packed {
      logic [8:0][31:0] att;
      logic [2:0][47:0] vel;
      logic [2:0][47:0] pos;
      logic             sat;
   } isi_motion_type;

   function automatic logic [63:0] lim_value(input isi_lim_type lim);
      logic [63:0] v;
      unique case (lim)
         LIM_Q30: v = LIM_Q30_VAL;
         LIM_Q47: v = LIM_Q47_VAL;
         LIM_DT:  v = LIM_DT_VAL;
         default: v = LIM_FULL_VAL;
      endcase
      return v;
   endfunction

   function automatic logic signed [63:0] sext32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic signed [63:0] sext48(input logic [47:0] x);
      return {{16{x[47]}}, x};
   endfunction

   function automatic logic [31:0] clamp_q30(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > LIM_Q30_VAL) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -LIM_Q30_VAL) begin
         r = 32'h8000_0001;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // flag in the top bit, clamped value below
   function automatic logic [48:0] clamp_q47(input logic signed [63:0] v);
      logic [48:0] r;
      if (v > LIM_Q47_VAL) begin
         r = {1'b1, 48'h7FFF_FFFF_FFFF};
      end else if (v < -LIM_Q47_VAL) begin
         r = {1'b1, 48'h8000_0000_0001};
      end else begin
         r = {1'b0, v[47:0]};
      end
      return r;
   endfunction

endpackage

// ----- rtl/isi_mul.sv -----
// Shared multiply, shift and clamp unit built on one 32x32 multiplier.
module isi_mul import isi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  isi_mul_req_type mreq,
   output isi_mul_rsp_type mrsp
);

   isi_mul_state_type state_ff, state_in;
   logic [1:0]         part_ff;
   logic [63:0]        ua_ff, ub_ff;
   logic               neg_ff;
   logic [6:0]         shift_ff;
   isi_lim_type        lim_ff;
   logic [127:0]       acc_ff;
   logic signed [63:0] res_ff;
   logic               ovf_ff;
   logic               done_ff;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [6:0]   pp_shamt;
   logic [127:0] pp_wide;
   logic [63:0]  limv;
   logic         over;
   logic [63:0]  mag;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE:  if (mreq.start) state_in = MUL_PROD;
         MUL_PROD:  if (part_ff == 2'd3) state_in = MUL_SHIFT;
         MUL_SHIFT: state_in = MUL_CLAMP;
         MUL_CLAMP: state_in = MUL_IDLE;
         default:   state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      a_half = part_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_half = part_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp = a_half * b_half;
      unique case (part_ff)
         2'd0:    pp_shamt = 7'd0;
         2'd3:    pp_shamt = 7'd64;
         default: pp_shamt = 7'd32;
      endcase
      pp_wide = {64'd0, pp} << pp_shamt;
      limv = lim_value(lim_ff);
      over = (acc_ff[127:64] != 64'd0) || (acc_ff[63:0] > limv);
      mag = over ? limv : acc_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= (state_ff == MUL_CLAMP);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         MUL_IDLE: begin
            ua_ff <= mreq.a[63] ? -mreq.a : mreq.a;
            ub_ff <= mreq.b[63] ? -mreq.b : mreq.b;
            neg_ff <= mreq.a[63] ^ mreq.b[63];
            shift_ff <= mreq.shift;
            lim_ff <= mreq.lim;
            acc_ff <= 128'd0;
            part_ff <= 2'd0;
         end
         MUL_PROD: begin
            acc_ff <= acc_ff + pp_wide;
            part_ff <= part_ff + 2'd1;
         end
         MUL_SHIFT: acc_ff <= acc_ff >> shift_ff;
         MUL_CLAMP: begin
            res_ff <= neg_ff ? -$signed(mag) : $signed(mag);
            ovf_ff <= over;
         end
         default: part_ff <= 2'd0;
      endcase
   end

   assign mrsp.done = done_ff;
   assign mrsp.res = res_ff;
   assign mrsp.ovf = ovf_ff;

endmodule

// ----- rtl/isi_engine.sv -----
// Integration sequencer: attitude exponential, midpoint acceleration, velocity and position.
module isi_engine import isi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  isi_req_type    item,
   input  isi_cfg_type    cfg,
   output logic           done,
   output isi_motion_type motion
);

   isi_eng_state_type state_ff, state_in;
   logic [1:0] i_ff, j_ff, m_ff;
   logic [3:0] n_ff;
   logic       ab_ff;
   logic       issued_ff;

   isi_req_type      cur_ff;
   logic [8:0][31:0] att_ff, nx_ff, e_ff;
   logic [2:0][47:0] vel_ff, pos_ff;
   logic             sat_ff;
   logic [31:0]      prev_time_ff;
   logic [2:0][31:0] prev_gyro_ff, prev_accel_ff;
   logic             have_prev_ff;

   logic [2:0][31:0]   th_ff;
   logic [47:0]        dt_ff;
   logic signed [63:0] dt2_ff, x60_ff, sa_ff, sb_ff, mm_ff, ek_ff, acc_ff, t1_ff;
   logic [2:0][63:0]   u0_ff, u1_ff;

   isi_mul_req_type mreq;
   isi_mul_rsp_type mrsp;

   logic [2:0][31:0]   cur_gyro, cur_accel, grav;
   logic signed [32:0] gsum;
   logic [31:0]        ticks;
   logic [3:0]         im_idx, mj_idx, ij_idx;
   logic signed [63:0] kval, y60, xq, usum, uhalf_pre, aw, grav_term;
   logic signed [63:0] ev, nsum, psum, vsum;
   logic [48:0]        pos_cl, vel_cl;
   logic               diag, ij_last;

   isi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   always_comb begin
      cur_gyro = {cur_ff.gyro_z, cur_ff.gyro_y, cur_ff.gyro_x};
      cur_accel = {cur_ff.accel_z, cur_ff.accel_y, cur_ff.accel_x};
      grav = {cfg.gravity_z, cfg.gravity_y, cfg.gravity_x};
      gsum = $signed({cur_gyro[i_ff][31], cur_gyro[i_ff]})
           + $signed({prev_gyro_ff[i_ff][31], prev_gyro_ff[i_ff]});
      ticks = cur_ff.timestamp - prev_time_ff;
      im_idx = {2'b00, i_ff} * 4'd3 + {2'b00, m_ff};
      mj_idx = {2'b00, m_ff} * 4'd3 + {2'b00, j_ff};
      ij_idx = {2'b00, i_ff} * 4'd3 + {2'b00, j_ff};
      diag = (i_ff == j_ff);
      ij_last = (i_ff == 2'd2) && (j_ff == 2'd2);
      case ({i_ff, j_ff})
         4'b0001: kval = -sext32(th_ff[2]);
         4'b0010: kval = sext32(th_ff[1]);
         4'b0100: kval = sext32(th_ff[2]);
         4'b0110: kval = -sext32(th_ff[0]);
         4'b1000: kval = -sext32(th_ff[1]);
         4'b1001: kval = sext32(th_ff[0]);
         default: kval = 64'sd0;
      endcase
      y60 = {4'b0000, x60_ff[63:4]};
      xq = {2'b00, x60_ff[63:2]};
      usum = u0_ff[i_ff] + u1_ff[i_ff];
      uhalf_pre = usum + {63'd0, usum[63]};
      grav_term = {{16{grav[i_ff][31]}}, grav[i_ff], 16'd0};
      aw = (uhalf_pre >>> 1) + grav_term;
      ev = (diag ? ONE30 : 64'sd0) + ek_ff + mrsp.res;
      nsum = acc_ff + mrsp.res;
      psum = sext48(pos_ff[i_ff]) + t1_ff + mrsp.res;
      vsum = sext48(vel_ff[i_ff]) + mrsp.res;
      pos_cl = clamp_q47(psum);
      vel_cl = clamp_q47(vsum);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               state_in = (item.restart || !have_prev_ff) ? ENG_DONE : ENG_DT;
            end
         end
         ENG_DT:  if (mrsp.done) state_in = ENG_TH;
         ENG_TH:  if (mrsp.done && i_ff == 2'd2) state_in = ENG_SQ;
         ENG_SQ:  if (mrsp.done && i_ff == 2'd2) state_in = ENG_SER;
         ENG_SER: if (mrsp.done && ab_ff && n_ff == 4'd0) state_in = ENG_DT2;
         ENG_DT2: if (mrsp.done) state_in = ENG_EMM;
         ENG_EMM: if (mrsp.done) state_in = ENG_EK;
         ENG_EK:  if (mrsp.done) state_in = ENG_EB;
         ENG_EB:  if (mrsp.done) state_in = ij_last ? ENG_NX : ENG_EMM;
         ENG_NX:  if (mrsp.done && ij_last && m_ff == 2'd2) state_in = ENG_U0;
         ENG_U0:  if (mrsp.done && i_ff == 2'd2 && m_ff == 2'd2) state_in = ENG_U1;
         ENG_U1:  if (mrsp.done && i_ff == 2'd2 && m_ff == 2'd2) state_in = ENG_T1;
         ENG_T1:  if (mrsp.done) state_in = ENG_T2;
         ENG_T2:  if (mrsp.done) state_in = ENG_DV;
         ENG_DV:  if (mrsp.done) state_in = (i_ff == 2'd2) ? ENG_DONE : ENG_T1;
         ENG_DONE: state_in = ENG_IDLE;
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      mreq.start = 1'b0;
      mreq.a = 64'sd0;
      mreq.b = 64'sd0;
      mreq.shift = 7'd0;
      mreq.lim = LIM_FULL;
      done = 1'b0;
      unique case (state_ff)
         ENG_DT: begin
            mreq.a = {32'd0, ticks};
            mreq.b = {32'd0, cfg.tick_period};
            mreq.lim = LIM_DT;
         end
         ENG_TH: begin
            mreq.a = {{31{gsum[32]}}, gsum};
            mreq.b = {16'd0, dt_ff};
            mreq.shift = 7'd19;
            mreq.lim = LIM_Q30;
         end
         ENG_SQ: begin
            mreq.a = sext32(th_ff[i_ff]);
            mreq.b = sext32(th_ff[i_ff]);
         end
         ENG_SER: begin
            mreq.a = ab_ff ? sb_ff : sa_ff;
            mreq.b = y60;
            mreq.shift = 7'd60;
         end
         ENG_DT2: begin
            mreq.a = {16'd0, dt_ff};
            mreq.b = {16'd0, dt_ff};
            mreq.shift = 7'd32;
         end
         ENG_EMM: begin
            mreq.a = sext32(th_ff[i_ff]);
            mreq.b = sext32(th_ff[j_ff]);
            mreq.shift = 7'd2;
         end
         ENG_EK: begin
            mreq.a = sa_ff;
            mreq.b = kval;
            mreq.shift = 7'd60;
         end
         ENG_EB: begin
            mreq.a = sb_ff;
            mreq.b = mm_ff;
            mreq.shift = 7'd88;
         end
         ENG_NX: begin
            mreq.a = sext32(att_ff[im_idx]);
            mreq.b = sext32(e_ff[mj_idx]);
            mreq.shift = 7'd30;
         end
         ENG_U0: begin
            mreq.a = sext32(att_ff[im_idx]);
            mreq.b = sext32(prev_accel_ff[m_ff]);
            mreq.shift = 7'd14;
         end
         ENG_U1: begin
            mreq.a = sext32(nx_ff[im_idx]);
            mreq.b = sext32(cur_accel[m_ff]);
            mreq.shift = 7'd14;
         end
         ENG_T1: begin
            mreq.a = sext48(vel_ff[i_ff]);
            mreq.b = {16'd0, dt_ff};
            mreq.shift = 7'd32;
            mreq.lim = LIM_Q47;
         end
         ENG_T2: begin
            mreq.a = aw;
            mreq.b = dt2_ff;
            mreq.shift = 7'd33;
            mreq.lim = LIM_Q47;
         end
         ENG_DV: begin
            mreq.a = aw;
            mreq.b = {16'd0, dt_ff};
            mreq.shift = 7'd32;
            mreq.lim = LIM_Q47;
         end
         ENG_DONE: done = 1'b1;
         default: done = 1'b0;
      endcase
      if (state_ff != ENG_IDLE && state_ff != ENG_DONE) begin
         mreq.start = !issued_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         issued_ff <= 1'b0;
         i_ff <= 2'd0;
         j_ff <= 2'd0;
         m_ff <= 2'd0;
         n_ff <= 4'd0;
         ab_ff <= 1'b0;
         att_ff <= ATT_IDENTITY;
         vel_ff <= '0;
         pos_ff <= '0;
         sat_ff <= 1'b0;
         prev_time_ff <= 32'd0;
         prev_gyro_ff <= '0;
         prev_accel_ff <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mreq.start) issued_ff <= 1'b1;
         if (mrsp.done) issued_ff <= 1'b0;
         unique case (state_ff)
            ENG_IDLE: begin
               i_ff <= 2'd0;
               j_ff <= 2'd0;
               m_ff <= 2'd0;
               ab_ff <= 1'b0;
               if (start && item.restart) begin
                  att_ff <= ATT_IDENTITY;
                  vel_ff <= '0;
                  pos_ff <= '0;
                  sat_ff <= 1'b0;
               end
            end
            ENG_TH, ENG_SQ: begin
               if (mrsp.done) begin
                  i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
                  n_ff <= 4'(SER_TERMS - 2);
               end
            end
            ENG_SER: begin
               if (mrsp.done) begin
                  ab_ff <= ~ab_ff;
                  if (ab_ff) n_ff <= n_ff - 4'd1;
               end
            end
            ENG_EB: begin
               if (mrsp.done) begin
                  j_ff <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
                  if (j_ff == 2'd2) i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
               end
            end
            ENG_NX: begin
               if (mrsp.done) begin
                  m_ff <= (m_ff == 2'd2) ? 2'd0 : m_ff + 2'd1;
                  if (m_ff == 2'd2) begin
                     j_ff <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
                     if (j_ff == 2'd2) i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
                  end
               end
            end
            ENG_U0, ENG_U1: begin
               if (mrsp.done) begin
                  m_ff <= (m_ff == 2'd2) ? 2'd0 : m_ff + 2'd1;
                  if (m_ff == 2'd2) i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
               end
            end
            ENG_T1: if (mrsp.done) sat_ff <= sat_ff | mrsp.ovf;
            ENG_T2: begin
               if (mrsp.done) begin
                  pos_ff[i_ff] <= pos_cl[47:0];
                  sat_ff <= sat_ff | mrsp.ovf | pos_cl[48];
               end
            end
            ENG_DV: begin
               if (mrsp.done) begin
                  vel_ff[i_ff] <= vel_cl[47:0];
                  sat_ff <= sat_ff | mrsp.ovf | vel_cl[48];
                  i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
                  if (i_ff == 2'd2) att_ff <= nx_ff;
               end
            end
            ENG_DONE: begin
               prev_time_ff <= cur_ff.timestamp;
               prev_gyro_ff <= cur_gyro;
               prev_accel_ff <= cur_accel;
               have_prev_ff <= 1'b1;
            end
            default: ab_ff <= ab_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ENG_IDLE && start) cur_ff <= item;
      if (mrsp.done) begin
         case (state_ff)
            ENG_DT: begin
               dt_ff <= mrsp.res[47:0];
               x60_ff <= 64'sd0;
            end
            ENG_TH: th_ff[i_ff] <= mrsp.res[31:0];
            ENG_SQ: begin
               x60_ff <= x60_ff + mrsp.res;
               sa_ff <= SER_A[SER_TERMS - 1];
               sb_ff <= SER_B[SER_TERMS - 1];
            end
            ENG_SER: begin
               if (ab_ff) sb_ff <= SER_B[n_ff] + mrsp.res;
               else sa_ff <= SER_A[n_ff] + mrsp.res;
            end
            ENG_DT2: dt2_ff <= mrsp.res;
            ENG_EMM: begin
               mm_ff <= mrsp.res - (diag ? xq : 64'sd0);
               acc_ff <= 64'sd0;
            end
            ENG_EK: ek_ff <= mrsp.res;
            ENG_EB: e_ff[ij_idx] <= clamp_q30(ev);
            ENG_NX: begin
               if (m_ff == 2'd2) begin
                  nx_ff[ij_idx] <= clamp_q30(nsum);
                  acc_ff <= 64'sd0;
               end else begin
                  acc_ff <= nsum;
               end
            end
            ENG_U0: u0_ff[i_ff] <= (m_ff == 2'd0) ? mrsp.res : u0_ff[i_ff] + mrsp.res;
            ENG_U1: u1_ff[i_ff] <= (m_ff == 2'd0) ? mrsp.res : u1_ff[i_ff] + mrsp.res;
            ENG_T1: t1_ff <= mrsp.res;
            default: t1_ff <= t1_ff;
         endcase
      end
   end

   assign motion.att = att_ff;
   assign motion.vel = vel_ff;
   assign motion.pos = pos_ff;
   assign motion.sat = sat_ff;

endmodule

// ----- rtl/imu_strapdown_integrator_core.sv -----
// Top level: item handshake, configuration registers and result sequencing.
// An integrating item runs 115 products through the shared 64x64 multiply unit
// before its first result; a restart item or the first sample runs none of them.
// Each item then emits 5 results.
// One item at a time: the next item is taken after the last result is delivered.
// Synchronous reset: identity attitude, zero motion, default gravity and tick period.
module imu_strapdown_integrator_core import isi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  isi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output isi_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   isi_top_state_type state_ff, state_in;
   isi_kind_type      kind_ff;
   isi_cfg_type       cfg_ff;
   isi_motion_type    motion;
   logic              eng_start, eng_done, accept;

   isi_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (eng_start),
      .item   (req_data),
      .cfg    (cfg_ff),
      .done   (eng_done),
      .motion (motion)
   );

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: if (accept) state_in = TOP_RUN;
         TOP_RUN:  if (eng_done) state_in = TOP_EMIT;
         TOP_EMIT: if (!rsp_stall && kind_ff == KIND_POS) state_in = TOP_IDLE;
         default:  state_in = TOP_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != TOP_IDLE);
      rsp_valid = (state_ff == TOP_EMIT);
      eng_start = accept;
      csr_ready = 1'b1;
      rsp_data.kind = kind_ff;
      rsp_data.saturated = motion.sat;
      rsp_data.last = (kind_ff == KIND_POS);
      unique case (kind_ff)
         KIND_ROW0: begin
            rsp_data.value_x = {{14{motion.att[0][31]}}, motion.att[0], 2'b00};
            rsp_data.value_y = {{14{motion.att[1][31]}}, motion.att[1], 2'b00};
            rsp_data.value_z = {{14{motion.att[2][31]}}, motion.att[2], 2'b00};
         end
         KIND_ROW1: begin
            rsp_data.value_x = {{14{motion.att[3][31]}}, motion.att[3], 2'b00};
            rsp_data.value_y = {{14{motion.att[4][31]}}, motion.att[4], 2'b00};
            rsp_data.value_z = {{14{motion.att[5][31]}}, motion.att[5], 2'b00};
         end
         KIND_ROW2: begin
            rsp_data.value_x = {{14{motion.att[6][31]}}, motion.att[6], 2'b00};
            rsp_data.value_y = {{14{motion.att[7][31]}}, motion.att[7], 2'b00};
            rsp_data.value_z = {{14{motion.att[8][31]}}, motion.att[8], 2'b00};
         end
         KIND_VEL: begin
            rsp_data.value_x = motion.vel[0];
            rsp_data.value_y = motion.vel[1];
            rsp_data.value_z = motion.vel[2];
         end
         default: begin
            rsp_data.value_x = motion.pos[0];
            rsp_data.value_y = motion.pos[1];
            rsp_data.value_z = motion.pos[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         kind_ff <= KIND_ROW0;
         cfg_ff.gravity_x <= 32'sd0;
         cfg_ff.gravity_y <= 32'sd0;
         cfg_ff.gravity_z <= 32'sd0;
         cfg_ff.tick_period <= TICK_PERIOD_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == TOP_EMIT && !rsp_stall) begin
            kind_ff <= (kind_ff == KIND_POS) ? KIND_ROW0 : isi_kind_type'(kind_ff + 3'd1);
         end
         if (csr_valid && csr_ready) begin
            unique case (isi_csr_index_type'(csr_index))
               CSR_GRAVITY_X:   cfg_ff.gravity_x <= csr_wdata;
               CSR_GRAVITY_Y:   cfg_ff.gravity_y <= csr_wdata;
               CSR_GRAVITY_Z:   cfg_ff.gravity_z <= csr_wdata;
               CSR_TICK_PERIOD: cfg_ff.tick_period <= csr_wdata;
               default:         cfg_ff.tick_period <= cfg_ff.tick_period;
            endcase
         end
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("item accepted while results pending");
   assert property (@(posedge clock) disable iff (reset) eng_done |-> state_ff == TOP_RUN)
      else $error("engine finished outside of run");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=> !rsp_valid)
      else $error("result after last of item");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_RUN) |-> !rsp_valid)
      else $error("result shown while integrating");
`endif

endmodule
